// ===== design/rbli_pkg.sv =====
// package: types, constants and tables for range_bearing_landmark_init
`timescale 1ns / 1ps
`default_nettype none
package rbli_pkg;

    localparam int CAPACITY     = 256;
    localparam int CORDIC_STEPS = 16;
    localparam int SLOT_CNT_W   = ($clog2(CAPACITY + 1) > 9) ? $clog2(CAPACITY + 1) : 9;
    localparam int STEP_W       = $clog2(CORDIC_STEPS);
    localparam int OP_COUNT     = 18;
    localparam int OP_W         = 5;
    localparam logic signed [33:0] K_GAIN = 34'sd652032874;

    typedef enum logic [2:0] {
        REG_POSE_X       = 3'd0,
        REG_POSE_Y       = 3'd1,
        REG_POSE_HEADING = 3'd2,
        REG_NOISE_00     = 3'd3,
        REG_NOISE_01     = 3'd4,
        REG_NOISE_10     = 3'd5,
        REG_NOISE_11     = 3'd6,
        REG_USED_SLOTS   = 3'd7
    } t_cfg_reg;

    typedef struct packed {
        logic [2:0]  index;
        logic [31:0] data;
    } t_cfg_beat;

    typedef struct packed {
        logic [31:0] range;
        logic [15:0] bearing;
        logic        last_in_batch;
    } t_in_item;

    typedef struct packed {
        logic signed [31:0] landmark_x;
        logic signed [31:0] landmark_y;
        logic signed [47:0] cov_00;
        logic signed [47:0] cov_01;
        logic signed [47:0] cov_10;
        logic signed [47:0] cov_11;
        logic [7:0]         slot;
        logic               table_full;
        logic               batch_done;
    } t_out_item;

    // operand sources of the shared multiplier
    typedef enum logic [3:0] {
        OPD_R, OPD_C, OPD_S, OPD_RC, OPD_NRS,
        OPD_N00, OPD_N01, OPD_N10, OPD_N11,
        OPD_M00, OPD_M01, OPD_M10, OPD_M11
    } t_opnd;

    typedef enum logic [3:0] {
        DST_RC, DST_RS, DST_TMP,
        DST_M00, DST_M01, DST_M10, DST_M11,
        DST_P00, DST_P01, DST_P10, DST_P11
    } t_dst;

    typedef struct packed {
        t_opnd a;
        t_opnd b;
        logic  sh30;
        t_dst  dst;
    } t_op;

    typedef struct packed {
        logic              start;
        logic              cordic;
        logic [STEP_W-1:0] step;
        logic              load;
        logic              mul;
        logic [1:0]        mul_j;
        logic              round;
        logic              write;
        logic [OP_W-1:0]   op;
        logic              finish;
    } t_dp_cmd;

    // microcode of the product sequence; odd entries from 3 on add the held term
    function automatic t_op op_entry(input logic [OP_W-1:0] k);
        t_op o;
        o = '{a: OPD_R, b: OPD_C, sh30: 1'b1, dst: DST_RC};
        unique case (k)
            5'd0:  o = '{a: OPD_R,   b: OPD_C,   sh30: 1'b1, dst: DST_RC};
            5'd1:  o = '{a: OPD_R,   b: OPD_S,   sh30: 1'b1, dst: DST_RS};
            5'd2:  o = '{a: OPD_C,   b: OPD_N00, sh30: 1'b1, dst: DST_TMP};
            5'd3:  o = '{a: OPD_NRS, b: OPD_N10, sh30: 1'b0, dst: DST_M00};
            5'd4:  o = '{a: OPD_C,   b: OPD_N01, sh30: 1'b1, dst: DST_TMP};
            5'd5:  o = '{a: OPD_NRS, b: OPD_N11, sh30: 1'b0, dst: DST_M01};
            5'd6:  o = '{a: OPD_S,   b: OPD_N00, sh30: 1'b1, dst: DST_TMP};
            5'd7:  o = '{a: OPD_RC,  b: OPD_N10, sh30: 1'b0, dst: DST_M10};
            5'd8:  o = '{a: OPD_S,   b: OPD_N01, sh30: 1'b1, dst: DST_TMP};
            5'd9:  o = '{a: OPD_RC,  b: OPD_N11, sh30: 1'b0, dst: DST_M11};
            5'd10: o = '{a: OPD_M00, b: OPD_C,   sh30: 1'b1, dst: DST_TMP};
            5'd11: o = '{a: OPD_M01, b: OPD_NRS, sh30: 1'b0, dst: DST_P00};
            5'd12: o = '{a: OPD_M00, b: OPD_S,   sh30: 1'b1, dst: DST_TMP};
            5'd13: o = '{a: OPD_M01, b: OPD_RC,  sh30: 1'b0, dst: DST_P01};
            5'd14: o = '{a: OPD_M10, b: OPD_C,   sh30: 1'b1, dst: DST_TMP};
            5'd15: o = '{a: OPD_M11, b: OPD_NRS, sh30: 1'b0, dst: DST_P10};
            5'd16: o = '{a: OPD_M10, b: OPD_S,   sh30: 1'b1, dst: DST_TMP};
            5'd17: o = '{a: OPD_M11, b: OPD_RC,  sh30: 1'b0, dst: DST_P11};
            default: o = '{a: OPD_R, b: OPD_C, sh30: 1'b1, dst: DST_RC};
        endcase
        return o;
    endfunction

    // arctangent table, 32 bit binary angle
    function automatic logic [31:0] atan_entry(input logic [4:0] i);
        logic [31:0] v;
        v = 32'd0;
        unique case (i)
            5'd0:  v = 32'd536870912;
            5'd1:  v = 32'd316933406;
            5'd2:  v = 32'd167458907;
            5'd3:  v = 32'd85004756;
            5'd4:  v = 32'd42667331;
            5'd5:  v = 32'd21354465;
            5'd6:  v = 32'd10679838;
            5'd7:  v = 32'd5340245;
            5'd8:  v = 32'd2670163;
            5'd9:  v = 32'd1335087;
            5'd10: v = 32'd667544;
            5'd11: v = 32'd333772;
            5'd12: v = 32'd166886;
            5'd13: v = 32'd83443;
            5'd14: v = 32'd41722;
            5'd15: v = 32'd20861;
            5'd16: v = 32'd10430;
            5'd17: v = 32'd5215;
            5'd18: v = 32'd2608;
            5'd19: v = 32'd1304;
            5'd20: v = 32'd652;
            5'd21: v = 32'd326;
            5'd22: v = 32'd163;
            5'd23: v = 32'd81;
            5'd24: v = 32'd41;
            5'd25: v = 32'd20;
            5'd26: v = 32'd10;
            5'd27: v = 32'd5;
            5'd28: v = 32'd3;
            5'd29: v = 32'd1;
            5'd30: v = 32'd1;
            5'd31: v = 32'd0;
            default: v = 32'd0;
        endcase
        return v;
    endfunction

endpackage
`default_nettype wire

// ===== design/rbli_ifs.sv =====
// valid/ready channel interfaces: measurement in, landmark out, register writes
`timescale 1ns / 1ps
`default_nettype none
interface rbli_in_if;
    logic               valid;
    logic               ready;
    rbli_pkg::t_in_item data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface rbli_out_if;
    logic                valid;
    logic                ready;
    rbli_pkg::t_out_item data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface rbli_cfg_if;
    logic                valid;
    logic                ready;
    rbli_pkg::t_cfg_beat data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface
`default_nettype wire

// ===== design/rbli_ctrl.sv =====
// sequencer: cordic iterations then the shared-multiplier product program
`timescale 1ns / 1ps
`default_nettype none
module rbli_ctrl (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_in_valid,
    output logic                   o_in_ready,
    output logic                   o_out_valid,
    input  wire logic              i_out_ready,
    output rbli_pkg::t_dp_cmd      o_cmd
);
    import rbli_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE, S_CORDIC, S_LOAD, S_MUL, S_DRAIN, S_ROUND, S_WRITE, S_FINAL
    } t_state;

    t_state            r_state;
    logic [STEP_W-1:0] r_step;
    logic [OP_W-1:0]   r_op;
    logic [1:0]        r_mj;
    logic              r_out_valid;
    logic              w_fin;

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;
    assign w_fin       = (r_state == S_FINAL) && (!r_out_valid || i_out_ready);

    always_comb begin
        o_cmd        = '0;
        o_cmd.start  = (r_state == S_IDLE) && i_in_valid;
        o_cmd.cordic = (r_state == S_CORDIC);
        o_cmd.step   = r_step;
        o_cmd.load   = (r_state == S_LOAD);
        o_cmd.mul    = (r_state == S_MUL);
        o_cmd.mul_j  = r_mj;
        o_cmd.round  = (r_state == S_ROUND);
        o_cmd.write  = (r_state == S_WRITE);
        o_cmd.op     = r_op;
        o_cmd.finish = w_fin;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_step      <= '0;
            r_op        <= '0;
            r_mj        <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_fin) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    r_step <= '0;
                    r_op   <= '0;
                    if (i_in_valid) begin
                        r_state <= S_CORDIC;
                    end
                end
                S_CORDIC: begin
                    if (r_step == STEP_W'(CORDIC_STEPS - 1)) begin
                        r_state <= S_LOAD;
                    end else begin
                        r_step <= r_step + 1'b1;
                    end
                end
                S_LOAD: begin
                    r_mj    <= '0;
                    r_state <= S_MUL;
                end
                S_MUL: begin
                    if (r_mj == 2'd3) begin
                        r_state <= S_DRAIN;
                    end else begin
                        r_mj <= r_mj + 1'b1;
                    end
                end
                S_DRAIN: r_state <= S_ROUND;
                S_ROUND: r_state <= S_WRITE;
                S_WRITE: begin
                    if (r_op == OP_W'(OP_COUNT - 1)) begin
                        r_state <= S_FINAL;
                    end else begin
                        r_op    <= r_op + 1'b1;
                        r_state <= S_LOAD;
                    end
                end
                S_FINAL: begin
                    if (w_fin) begin
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end
endmodule
`default_nettype wire

// ===== design/rbli_dp.sv =====
// datapath: registers, cordic, shared 24x24 multiplier, rounding and slot counter
`timescale 1ns / 1ps
`default_nettype none
module rbli_dp (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_cfg_we,
    input  rbli_pkg::t_cfg_beat      i_cfg,
    input  rbli_pkg::t_in_item       i_item,
    input  rbli_pkg::t_dp_cmd        i_cmd,
    output rbli_pkg::t_out_item      o_item
);
    import rbli_pkg::*;

    // configuration and slot counter
    logic signed [31:0]    r_pose_x, r_pose_y;
    logic [15:0]           r_heading;
    logic signed [31:0]    r_n00, r_n01, r_n10, r_n11;
    logic [SLOT_CNT_W-1:0] r_slot_cnt;
    logic                  w_full;

    // working registers
    logic [31:0]        r_range;
    logic               r_last;
    logic               r_flip;
    logic signed [33:0] r_x, r_y, r_z;
    logic signed [47:0] r_rc, r_rs, r_tmp, r_prod;
    logic signed [47:0] r_m00, r_m01, r_m10, r_m11;
    logic signed [47:0] r_p00, r_p01, r_p10, r_p11;
    logic               r_neg;
    logic [47:0]        r_amag, r_bmag;
    logic [47:0]        r_pp;
    logic [1:0]         r_pp_k;
    logic               r_pp_vld;
    logic [95:0]        r_acc;
    t_out_item          r_out;

    logic [15:0]        w_ang, w_ang_q;
    logic               w_flip;
    logic [31:0]        w_a32;
    logic signed [33:0] w_c, w_s, w_dx, w_dy, w_atan;
    t_op                w_op;
    logic signed [48:0] w_a, w_b, w_amag, w_bmag;
    logic [23:0]        w_pa, w_pb;
    logic [96:0]        w_rnd, w_q;
    logic [47:0]        w_lim, w_qs;
    logic signed [48:0] w_sum;
    logic signed [47:0] w_sat;
    logic signed [48:0] w_lx, w_ly;

    assign o_item = r_out;
    assign w_full = (r_slot_cnt >= SLOT_CNT_W'(CAPACITY));

    // angle prep: half turn around pi is folded by a rotation of pi
    assign w_ang   = r_heading + i_item.bearing;
    assign w_ang_q = w_ang + 16'h4000;
    assign w_flip  = w_ang_q[15];
    assign w_a32   = {w_ang ^ {w_flip, 15'd0}, 16'd0};

    assign w_c    = r_flip ? -r_x : r_x;
    assign w_s    = r_flip ? -r_y : r_y;
    assign w_dx   = r_y >>> i_cmd.step;
    assign w_dy   = r_x >>> i_cmd.step;
    assign w_atan = {2'b00, atan_entry(5'(i_cmd.step))};

    assign w_op = op_entry(i_cmd.op);

    function automatic logic signed [48:0] pick(input t_opnd sel,
            input logic [31:0] rr, input logic signed [33:0] c,
            input logic signed [33:0] s, input logic signed [47:0] rc,
            input logic signed [47:0] rs, input logic signed [31:0] n00,
            input logic signed [31:0] n01, input logic signed [31:0] n10,
            input logic signed [31:0] n11, input logic signed [47:0] m00,
            input logic signed [47:0] m01, input logic signed [47:0] m10,
            input logic signed [47:0] m11);
        logic signed [48:0] v;
        v = '0;
        unique case (sel)
            OPD_R:   v = {17'd0, rr};
            OPD_C:   v = 49'(c);
            OPD_S:   v = 49'(s);
            OPD_RC:  v = 49'(rc);
            OPD_NRS: v = -49'(rs);
            OPD_N00: v = 49'(n00);
            OPD_N01: v = 49'(n01);
            OPD_N10: v = 49'(n10);
            OPD_N11: v = 49'(n11);
            OPD_M00: v = 49'(m00);
            OPD_M01: v = 49'(m01);
            OPD_M10: v = 49'(m10);
            OPD_M11: v = 49'(m11);
            default: v = '0;
        endcase
        return v;
    endfunction

    assign w_a = pick(w_op.a, r_range, w_c, w_s, r_rc, r_rs, r_n00, r_n01, r_n10,
                      r_n11, r_m00, r_m01, r_m10, r_m11);
    assign w_b = pick(w_op.b, r_range, w_c, w_s, r_rc, r_rs, r_n00, r_n01, r_n10,
                      r_n11, r_m00, r_m01, r_m10, r_m11);
    assign w_amag = w_a[48] ? -w_a : w_a;
    assign w_bmag = w_b[48] ? -w_b : w_b;

    // partial product j: bit 0 picks the half of a, bit 1 the half of b
    assign w_pa = i_cmd.mul_j[0] ? r_amag[47:24] : r_amag[23:0];
    assign w_pb = i_cmd.mul_j[1] ? r_bmag[47:24] : r_bmag[23:0];

    // round half away from zero on the magnitude, then clamp
    assign w_rnd = {1'b0, r_acc} + (w_op.sh30 ? (97'd1 << 29) : (97'd1 << 15));
    assign w_q   = w_op.sh30 ? (w_rnd >> 30) : (w_rnd >> 16);
    assign w_lim = r_neg ? 48'h8000_0000_0000 : 48'h7FFF_FFFF_FFFF;
    assign w_qs  = (w_q > 97'(w_lim)) ? w_lim : w_q[47:0];

    assign w_sum = 49'(r_tmp) + 49'(r_prod);
    assign w_sat = (w_sum > 49'sh0_7FFF_FFFF_FFFF) ? 48'sh7FFF_FFFF_FFFF :
                   (w_sum < -49'sh0_8000_0000_0000) ? 48'sh8000_0000_0000 :
                   w_sum[47:0];

    assign w_lx = 49'(r_pose_x) + 49'(r_rc);
    assign w_ly = 49'(r_pose_y) + 49'(r_rs);

    function automatic logic signed [31:0] sat32(input logic signed [48:0] v);
        logic signed [31:0] o;
        if (v > 49'sd2147483647) begin
            o = 32'sh7FFF_FFFF;
        end else if (v < -49'sd2147483648) begin
            o = 32'sh8000_0000;
        end else begin
            o = v[31:0];
        end
        return o;
    endfunction

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pose_x   <= '0;
            r_pose_y   <= '0;
            r_heading  <= '0;
            r_n00      <= '0;
            r_n01      <= '0;
            r_n10      <= '0;
            r_n11      <= '0;
            r_slot_cnt <= '0;
            r_pp_vld   <= 1'b0;
        end else begin
            r_pp_vld <= i_cmd.mul;
            if (i_cfg_we) begin
                unique case (t_cfg_reg'(i_cfg.index))
                    REG_POSE_X:       r_pose_x   <= i_cfg.data;
                    REG_POSE_Y:       r_pose_y   <= i_cfg.data;
                    REG_POSE_HEADING: r_heading  <= i_cfg.data[15:0];
                    REG_NOISE_00:     r_n00      <= i_cfg.data;
                    REG_NOISE_01:     r_n01      <= i_cfg.data;
                    REG_NOISE_10:     r_n10      <= i_cfg.data;
                    REG_NOISE_11:     r_n11      <= i_cfg.data;
                    REG_USED_SLOTS:   r_slot_cnt <= SLOT_CNT_W'(i_cfg.data[8:0]);
                    default: ;
                endcase
            end else if (i_cmd.finish && !w_full) begin
                r_slot_cnt <= r_slot_cnt + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.start) begin
            r_range <= i_item.range;
            r_last  <= i_item.last_in_batch;
            r_flip  <= w_flip;
            r_x     <= K_GAIN;
            r_y     <= '0;
            r_z     <= 34'(signed'(w_a32));
        end
        if (i_cmd.cordic) begin
            if (!r_z[33]) begin
                r_x <= r_x - w_dx;
                r_y <= r_y + w_dy;
                r_z <= r_z - w_atan;
            end else begin
                r_x <= r_x + w_dx;
                r_y <= r_y - w_dy;
                r_z <= r_z + w_atan;
            end
        end
        if (i_cmd.load) begin
            r_amag <= w_amag[47:0];
            r_bmag <= w_bmag[47:0];
            r_neg  <= w_a[48] ^ w_b[48];
            r_acc  <= '0;
        end
        if (i_cmd.mul) begin
            r_pp   <= w_pa * w_pb;
            r_pp_k <= 2'(i_cmd.mul_j[0]) + 2'(i_cmd.mul_j[1]);
        end
        if (r_pp_vld) begin
            unique case (r_pp_k)
                2'd0:    r_acc <= r_acc + {48'd0, r_pp};
                2'd1:    r_acc <= r_acc + {24'd0, r_pp, 24'd0};
                2'd2:    r_acc <= r_acc + {r_pp, 48'd0};
                default: r_acc <= r_acc;
            endcase
        end
        if (i_cmd.round) begin
            r_prod <= r_neg ? -w_qs : w_qs;
        end
        if (i_cmd.write) begin
            unique case (w_op.dst)
                DST_RC:  r_rc  <= r_prod;
                DST_RS:  r_rs  <= r_prod;
                DST_TMP: r_tmp <= r_prod;
                DST_M00: r_m00 <= w_sat;
                DST_M01: r_m01 <= w_sat;
                DST_M10: r_m10 <= w_sat;
                DST_M11: r_m11 <= w_sat;
                DST_P00: r_p00 <= w_sat;
                DST_P01: r_p01 <= w_sat;
                DST_P10: r_p10 <= w_sat;
                DST_P11: r_p11 <= w_sat;
                default: ;
            endcase
        end
        if (i_cmd.finish) begin
            r_out.landmark_x <= sat32(w_lx);
            r_out.landmark_y <= sat32(w_ly);
            r_out.cov_00     <= r_p00;
            r_out.cov_01     <= r_p01;
            r_out.cov_10     <= r_p10;
            r_out.cov_11     <= r_p11;
            r_out.slot       <= w_full ? 8'd0 : 8'(r_slot_cnt);
            r_out.table_full <= w_full;
            r_out.batch_done <= r_last;
        end
    end
endmodule
`default_nettype wire

// ===== design/range_bearing_landmark_init.sv =====
// top level: new-landmark initialization from one range/bearing beat
`timescale 1ns / 1ps
`default_nettype none
// usage
// - i_in: one beat per new landmark (range Q16.16, bearing binary angle,
//   last_in_batch). ready is high only while the block is idle.
// - o_out: one beat per input beat with position, covariance, slot,
//   table_full and batch_done (an echo of last_in_batch).
// - i_cfg: register writes (index, data), always ready; write only while idle.
//   index 7 loads the used-slot counter.
// schedule: the cordic iterations first, then the single shared multiplier,
//   which runs 18 products of four 24x24 partial products each, plus
//   rounding and write-back per product.
// overlap: the next item is accepted only after the last one finishes; its
//   result waits in the output register while the next is accepted and computed.
// stall: if the receiver holds ready low, the next result waits in its last
//   step until the output register frees up; nothing is lost.
// reset: configuration registers and slot counter clear, output valid drops.
module range_bearing_landmark_init (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    rbli_in_if.sink   i_in,
    rbli_out_if.source o_out,
    rbli_cfg_if.sink  i_cfg
);
    import rbli_pkg::*;

    t_dp_cmd w_cmd;
    logic    w_in_ready;
    logic    w_out_valid;

    // config always accepted
    assign i_cfg.ready = 1'b1;
    assign i_in.ready  = w_in_ready;
    assign o_out.valid = w_out_valid;

    rbli_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in.valid),
        .o_in_ready  (w_in_ready),
        .o_out_valid (w_out_valid),
        .i_out_ready (o_out.ready),
        .o_cmd       (w_cmd)
    );

    rbli_dp u_dp (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cfg_we (i_cfg.valid),
        .i_cfg    (i_cfg.data),
        .i_item   (i_in.data),
        .i_cmd    (w_cmd),
        .o_item   (o_out.data)
    );
endmodule
`default_nettype wire
